### hw/rtl/dmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Direct-mapped cache package
// Geometry, field widths, command codes, controller states and the command
// and status bundles shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package dmc_pkg;

    // Cache and backing memory geometry.
    localparam int LINES        = 8;
    localparam int LINE_BYTES   = 16;
    localparam int MEMORY_BYTES = 4096;

    // Field widths.
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 8;
    localparam int OFFS_W  = $clog2(LINE_BYTES);
    localparam int LINE_W  = $clog2(LINES);
    localparam int BLOCK_W = ADDR_W - OFFS_W;
    localparam int TAG_W   = BLOCK_W - LINE_W;
    localparam int MEM_AW  = $clog2(MEMORY_BYTES);
    localparam int CBUF_AW = LINE_W + OFFS_W;
    localparam int CNT_W   = 32;

    // Reset value of the miss penalty register.
    localparam logic [DATA_W-1:0] PENALTY_RESET = 8'd20;

    // Last byte index within a line.
    localparam logic [OFFS_W-1:0] LAST_OFFS = OFFS_W'(LINE_BYTES - 1);

    // Saturation value of the counters.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Input command codes.
    localparam logic CMD_PRELOAD = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_FILL,
        S_DRAIN,
        S_RDREQ,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic preload;      // write the input byte into backing memory
        logic accept_read;  // capture the address of a read item
        logic lookup;       // compare tag, update counters, claim line on miss
        logic fill_step;    // read one backing byte for the line refill
        logic line_rd;      // read the addressed byte of the cache line
        logic load_out;     // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;          // tag of the captured address matches its line
        logic fill_last;    // refill counter is at the last byte of the line
        logic out_free;     // result register can take a new item
    } t_dp_sts;

endpackage

### hw/rtl/dmc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/dmc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cache controller
// State machine that sequences lookup, line refill, cache read and result
// hand-off, driving the datapath through a command bundle.
// ---------------------------------------------------------------------------
module dmc_ctrl
    import dmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_command,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_command == CMD_READ) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = i_sts.hit ? S_RDREQ : S_FILL;
            end
            S_FILL: begin
                if (i_sts.fill_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RDREQ;
            end
            S_RDREQ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready             = 1'b1;
                o_cmd.preload       = i_valid && i_command == CMD_PRELOAD;
                o_cmd.accept_read   = i_valid && i_command == CMD_READ;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_RDREQ: begin
                o_cmd.line_rd = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A read item always goes to the tag lookup next.
    a_read_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept_read |=> r_state == S_LOOKUP)
        else $error("read item did not enter lookup");

    // The last refill step is followed by the drain of the final write.
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_sts.fill_last) |=> r_state == S_DRAIN)
        else $error("refill did not end after the last byte");

    // A cache read is always followed by loading or waiting for the result slot.
    a_read_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.line_rd |=> r_state == S_DONE)
        else $error("cache read not followed by result stage");

endmodule

### hw/rtl/dmc_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cache datapath
// Backing memory, cache line memory, tag store, refill counter, saturating
// counters, the miss penalty register and the result register.
// ---------------------------------------------------------------------------
module dmc_dp
    import dmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [DATA_W-1:0]  i_write_data,
    input  logic               i_cfg_we,
    input  logic [DATA_W-1:0]  i_cfg_wdata,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [DATA_W-1:0]  o_read_data,
    output logic [TAG_W-1:0]   o_tag,
    output logic [LINE_W-1:0]  o_line_index,
    output logic [OFFS_W-1:0]  o_word_offset,
    output logic [BLOCK_W-1:0] o_block_number,
    output logic [CNT_W-1:0]   o_miss_count,
    output logic [CNT_W-1:0]   o_elapsed_time,
    output logic [CNT_W-1:0]   o_access_count
);

    // Captured address of the read item and its fields.
    logic [ADDR_W-1:0]  r_addr;
    logic [OFFS_W-1:0]  w_word;
    logic [LINE_W-1:0]  w_line;
    logic [TAG_W-1:0]   w_tag;
    logic [BLOCK_W-1:0] w_block;

    // Tag store with a valid bit per line.
    logic [TAG_W-1:0]   r_tags [LINES];
    logic [LINES-1:0]   r_valid;
    logic               r_hit;
    logic               w_hit;

    // Refill control.
    logic [OFFS_W-1:0]  r_cnt;
    logic               r_wr_pend;
    logic [OFFS_W-1:0]  r_wr_idx;

    // Counters and configuration.
    logic [DATA_W-1:0]  r_penalty;
    logic [CNT_W-1:0]   r_miss;
    logic [CNT_W-1:0]   r_time;
    logic [CNT_W-1:0]   r_acc;
    logic [CNT_W:0]     w_time_sum;

    // Memory ports.
    logic [MEM_AW-1:0]  w_bk_waddr;
    logic [MEM_AW-1:0]  w_bk_raddr;
    logic [DATA_W-1:0]  w_bk_rdata;
    logic [DATA_W-1:0]  w_cb_rdata;

    // Result register.
    logic               r_o_valid;
    logic               r_o_hit;
    logic [DATA_W-1:0]  r_o_data;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [CNT_W-1:0]   r_o_miss;
    logic [CNT_W-1:0]   r_o_time;
    logic [CNT_W-1:0]   r_o_acc;

    assign w_word  = r_addr[OFFS_W-1:0];
    assign w_block = r_addr[ADDR_W-1:OFFS_W];
    assign w_line  = w_block[LINE_W-1:0];
    assign w_tag   = w_block[BLOCK_W-1:LINE_W];

    // Tag compare against the addressed line.
    assign w_hit = r_valid[w_line] && (r_tags[w_line] == w_tag);

    // Address capture for a read item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_read) begin
            r_addr <= i_address;
        end
    end

    // Miss penalty register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty <= PENALTY_RESET;
        end else if (i_cfg_we) begin
            r_penalty <= i_cfg_wdata;
        end
    end

    // Tag store: a miss claims the line at lookup.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.lookup && !w_hit) begin
            r_valid[w_line] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup && !w_hit) begin
            r_tags[w_line] <= w_tag;
        end
        if (i_cmd.lookup) begin
            r_hit <= w_hit;
        end
    end

    // Saturating counters, updated once per read at lookup.
    assign w_time_sum = {1'b0, r_time} + {{(CNT_W + 1 - DATA_W){1'b0}}, r_penalty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
            r_time <= '0;
            r_acc  <= '0;
        end else if (i_cmd.lookup) begin
            if (r_acc != CNT_MAX) begin
                r_acc <= r_acc + 1'b1;
            end
            if (!w_hit) begin
                if (r_miss != CNT_MAX) begin
                    r_miss <= r_miss + 1'b1;
                end
                r_time <= w_time_sum[CNT_W] ? CNT_MAX : w_time_sum[CNT_W-1:0];
            end
        end
    end

    // Refill counter and delayed write of each fetched byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.fill_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_cnt <= '0;
        end else if (i_cmd.fill_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.fill_step) begin
            r_wr_idx <= r_cnt;
        end
    end

    // Backing memory: preload writes, refill reads one byte per cycle.
    assign w_bk_waddr = i_address[MEM_AW-1:0];
    assign w_bk_raddr = {w_block, r_cnt};

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_BYTES)
    ) u_backing (
        .i_clk   (i_clk),
        .i_we    (i_cmd.preload),
        .i_waddr (w_bk_waddr),
        .i_wdata (i_write_data),
        .i_re    (i_cmd.fill_step),
        .i_raddr (w_bk_raddr),
        .o_rdata (w_bk_rdata)
    );

    // Cache line memory: refill writes, one byte read per item.
    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINES * LINE_BYTES)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_wr_pend),
        .i_waddr ({w_line, r_wr_idx}),
        .i_wdata (w_bk_rdata),
        .i_re    (i_cmd.line_rd),
        .i_raddr ({w_line, w_word}),
        .o_rdata (w_cb_rdata)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_hit  <= r_hit;
            r_o_data <= w_cb_rdata;
            r_o_addr <= r_addr;
            r_o_miss <= r_miss;
            r_o_time <= r_time;
            r_o_acc  <= r_acc;
        end
    end

    // Status to the controller.
    assign o_sts.hit       = w_hit;
    assign o_sts.fill_last = (r_cnt == LAST_OFFS);
    assign o_sts.out_free  = !r_o_valid || i_ready;

    assign o_valid        = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_read_data    = r_o_data;
    assign o_tag          = r_o_addr[ADDR_W-1:ADDR_W-TAG_W];
    assign o_line_index   = r_o_addr[CBUF_AW-1:OFFS_W];
    assign o_word_offset  = r_o_addr[OFFS_W-1:0];
    assign o_block_number = r_o_addr[ADDR_W-1:OFFS_W];
    assign o_miss_count   = r_o_miss;
    assign o_elapsed_time = r_o_time;
    assign o_access_count = r_o_acc;

    // After a lookup the addressed line always holds the item's tag.
    a_line_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> (r_valid[w_line] && r_tags[w_line] == w_tag))
        else $error("line not claimed after lookup");

    // Misses never outnumber accesses.
    a_miss_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= r_acc)
        else $error("miss count exceeds access count");

    // The access counter never goes backwards outside reset.
    a_acc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_acc >= $past(r_acc))
        else $error("access counter decreased");

endmodule

### hw/rtl/direct_mapped_cache_read.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Direct-mapped read cache
// Eight lines of sixteen bytes in front of a 4096-byte backing memory, with
// saturating miss, access and elapsed-time counters.
// ---------------------------------------------------------------------------
// A preload item writes one backing byte. A read item passes through
// acceptance, lookup, cache read and result hand-off on a hit; a miss adds
// the line refill and a drain step after lookup, and the refill copies
// one byte per cycle through the single read port of the backing memory.
// One item is processed at a time; the finished result sits in an output
// register, so the next item is accepted while it waits to be taken. The
// backing memory holds no defined value until preloaded, and a read must
// only touch lines whose backing bytes were preloaded. The user must write
// the miss penalty only while the block is idle; the block does not enforce it.
module direct_mapped_cache_read
    import dmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [DATA_W-1:0]  i_write_data,
    input  logic               i_cfg_we,
    input  logic [DATA_W-1:0]  i_cfg_wdata,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [DATA_W-1:0]  o_read_data,
    output logic [TAG_W-1:0]   o_tag,
    output logic [LINE_W-1:0]  o_line_index,
    output logic [OFFS_W-1:0]  o_word_offset,
    output logic [BLOCK_W-1:0] o_block_number,
    output logic [CNT_W-1:0]   o_miss_count,
    output logic [CNT_W-1:0]   o_elapsed_time,
    output logic [CNT_W-1:0]   o_access_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    dmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Memories, tags, counters and result register.
    dmc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_read_data    (o_read_data),
        .o_tag          (o_tag),
        .o_line_index   (o_line_index),
        .o_word_offset  (o_word_offset),
        .o_block_number (o_block_number),
        .o_miss_count   (o_miss_count),
        .o_elapsed_time (o_elapsed_time),
        .o_access_count (o_access_count)
    );

endmodule
